/* design/sphere_frustum_cull_lod_defines.svh */
// assertion macros for the sphere frustum cull block
// no dependencies; included by files that carry concurrent assertions
`ifndef SPHERE_FRUSTUM_CULL_LOD_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_LOD_DEFINES_SVH
`ifndef SYNTHESIS
`define SFCL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfcl assertion failed");
`define SFCL_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfcl assertion failed");
`else
`define SFCL_ASSERT_IMP(name, clk, rst, ante, cons)
`define SFCL_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

/* design/sfcl_pkg.sv */
// types and constants for the sphere frustum cull block
// no dependencies; used by every module of the block
package sfcl_pkg;

   localparam int COORD_W      = 16;
   localparam int PROD_W       = 32;
   localparam int FRAC_SHIFT   = 14;
   localparam int DIST_W       = 35;
   localparam int T_W          = DIST_W - 1;
   localparam int DEPTH_W      = 20;
   localparam int DETAIL_W     = 16;
   localparam int NEAR_W       = 16;
   localparam int INV_W        = 32;
   localparam int INV_HALF     = INV_W / 2;
   localparam int PART_W       = T_W + INV_HALF;
   localparam int SUM_W        = PART_W + 1;
   localparam int DETAIL_SHIFT = 18;
   localparam int PLANE_COUNT  = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int NUM_STAGES   = 5;

   // pipeline stage positions
   localparam int STG_PROD  = 0;
   localparam int STG_SUM   = 1;
   localparam int STG_CULL  = 2;
   localparam int STG_SCALE = 3;
   localparam int STG_OUT   = 4;

   // plane slots
   localparam int PLANE_LEFT  = 0;
   localparam int PLANE_RIGHT = 1;
   localparam int PLANE_FAR   = 2;
   localparam int PLANE_NEAR  = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_LEFT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_RIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_FAR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_NEAR  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_DIST   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_RANGE   = 3'd5;

   typedef struct packed {
      logic signed [COORD_W-1:0] offset;
      logic signed [COORD_W-1:0] nz;
      logic signed [COORD_W-1:0] ny;
      logic signed [COORD_W-1:0] nx;
   } plane_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] centre_x;
      logic signed [COORD_W-1:0] centre_y;
      logic signed [COORD_W-1:0] centre_z;
      logic [COORD_W-1:0]        sphere_radius;
   } req_type;

   typedef struct packed {
      logic                visible;
      logic [DEPTH_W-1:0]  near_depth;
      logic [DETAIL_W-1:0] detail_level;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage

/* design/sfcl_plane_lane.sv */
// one plane lane: three products, then signed distance plus radius
// depends on sfcl_pkg
module sfcl_plane_lane (
   input  logic                                clock,
   input  sfcl_pkg::pipe_ctl_type              ctl,
   input  sfcl_pkg::plane_type                 plane,
   input  logic signed [sfcl_pkg::COORD_W-1:0] centre_x,
   input  logic signed [sfcl_pkg::COORD_W-1:0] centre_y,
   input  logic signed [sfcl_pkg::COORD_W-1:0] centre_z,
   input  logic [sfcl_pkg::COORD_W-1:0]        sphere_radius,
   output logic signed [sfcl_pkg::DIST_W-1:0]  dist_sum
);

   logic signed [sfcl_pkg::PROD_W-1:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [sfcl_pkg::PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [sfcl_pkg::COORD_W-1:0] offset_ff;
   logic [sfcl_pkg::COORD_W-1:0]        radius_ff;
   logic signed [sfcl_pkg::DIST_W-1:0]  offset_ext, radius_ext, sum_in, sum_ff;

   assign prod_x_in = $signed(plane.nx) * centre_x;
   assign prod_y_in = $signed(plane.ny) * centre_y;
   assign prod_z_in = $signed(plane.nz) * centre_z;

   always_ff @(posedge clock) begin
      if (ctl.load[sfcl_pkg::STG_PROD]) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         offset_ff <= plane.offset;
         radius_ff <= sphere_radius;
      end
   end

   assign offset_ext = sfcl_pkg::DIST_W'(offset_ff) <<< sfcl_pkg::FRAC_SHIFT;
   assign radius_ext = $signed({{(sfcl_pkg::DIST_W - sfcl_pkg::COORD_W
                                  - sfcl_pkg::FRAC_SHIFT){1'b0}},
                                radius_ff, {sfcl_pkg::FRAC_SHIFT{1'b0}}});
   assign sum_in = sfcl_pkg::DIST_W'(prod_x_ff) + sfcl_pkg::DIST_W'(prod_y_ff)
                 + sfcl_pkg::DIST_W'(prod_z_ff) + offset_ext + radius_ext;

   always_ff @(posedge clock) begin
      if (ctl.load[sfcl_pkg::STG_SUM]) begin
         sum_ff <= sum_in;
      end
   end

   assign dist_sum = sum_ff;

endmodule

/* design/sfcl_detail_scale.sv */
// detail scaling: split product by the inverse range, combine and clamp to Q0.16
// depends on sfcl_pkg
module sfcl_detail_scale (
   input  logic                             clock,
   input  sfcl_pkg::pipe_ctl_type           ctl,
   input  logic [sfcl_pkg::T_W-1:0]         span,
   input  logic [sfcl_pkg::INV_W-1:0]       inverse_range,
   output logic [sfcl_pkg::DETAIL_W-1:0]    detail_level
);

   logic [sfcl_pkg::PART_W-1:0]                       part_hi_in, part_lo_in;
   logic [sfcl_pkg::PART_W-1:0]                       part_hi_ff, part_lo_ff;
   logic [sfcl_pkg::SUM_W-1:0]                        total;
   logic [sfcl_pkg::SUM_W-sfcl_pkg::DETAIL_SHIFT-1:0] quot;
   logic [sfcl_pkg::DETAIL_W-1:0]                     detail_in, detail_ff;

   assign part_hi_in = sfcl_pkg::PART_W'(span)
      * sfcl_pkg::PART_W'(inverse_range[sfcl_pkg::INV_W-1:sfcl_pkg::INV_HALF]);
   assign part_lo_in = sfcl_pkg::PART_W'(span)
      * sfcl_pkg::PART_W'(inverse_range[sfcl_pkg::INV_HALF-1:0]);

   always_ff @(posedge clock) begin
      if (ctl.load[sfcl_pkg::STG_SCALE]) begin
         part_hi_ff <= part_hi_in;
         part_lo_ff <= part_lo_in;
      end
   end

   assign total = sfcl_pkg::SUM_W'(part_hi_ff)
                + sfcl_pkg::SUM_W'(part_lo_ff >> sfcl_pkg::INV_HALF);
   assign quot  = total[sfcl_pkg::SUM_W-1:sfcl_pkg::DETAIL_SHIFT];

   always_comb begin
      if (|quot[$bits(quot)-1:sfcl_pkg::DETAIL_W]) begin
         detail_in = '1;
      end else begin
         detail_in = quot[sfcl_pkg::DETAIL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[sfcl_pkg::STG_OUT]) begin
         detail_ff <= detail_in;
      end
   end

   assign detail_level = detail_ff;

endmodule

/* design/sphere_frustum_cull_lod.sv */
// throughput: one sphere per cycle while the output is not stalled
// five register stages with per-stage valid bits
// stages: products, plane sums, cull and near span, split detail product, output
// a stalled output lets earlier stages keep filling; bubbles are squeezed out
// reset: synchronous, clears all valid bits and the plane, near and range registers
`include "sphere_frustum_cull_lod_defines.svh"
module sphere_frustum_cull_lod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sfcl_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sfcl_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfcl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfcl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   sfcl_pkg::plane_type                 plane_ff [sfcl_pkg::PLANE_COUNT];
   logic [sfcl_pkg::NEAR_W-1:0]         near_ff;
   logic [sfcl_pkg::INV_W-1:0]          inv_ff;

   logic [sfcl_pkg::NUM_STAGES-1:0]     vld_ff, vld_in, rdy;
   sfcl_pkg::pipe_ctl_type              pipe_ctl;

   logic signed [sfcl_pkg::DIST_W-1:0]  lane_sum [sfcl_pkg::PLANE_COUNT];
   logic signed [sfcl_pkg::DIST_W-1:0]  s_near, near_ext, diff;
   logic                                culled_in;
   logic [sfcl_pkg::T_W-1:0]            span_in, span_ff;
   logic [sfcl_pkg::DEPTH_W-1:0]        depth_in;
   logic                                culled_s3_ff, culled_s4_ff;
   logic [sfcl_pkg::DEPTH_W-1:0]        depth_s3_ff, depth_s4_ff, depth_ff;
   logic                                visible_ff;
   logic [sfcl_pkg::DETAIL_W-1:0]       detail;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < sfcl_pkg::PLANE_COUNT; p++) begin
            plane_ff[p] <= '0;
         end
         near_ff <= '0;
         inv_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sfcl_pkg::CSR_PLANE_LEFT: begin
               plane_ff[sfcl_pkg::PLANE_LEFT] <= sfcl_pkg::plane_type'(csr_wdata);
            end
            sfcl_pkg::CSR_PLANE_RIGHT: begin
               plane_ff[sfcl_pkg::PLANE_RIGHT] <= sfcl_pkg::plane_type'(csr_wdata);
            end
            sfcl_pkg::CSR_PLANE_FAR: begin
               plane_ff[sfcl_pkg::PLANE_FAR] <= sfcl_pkg::plane_type'(csr_wdata);
            end
            sfcl_pkg::CSR_PLANE_NEAR: begin
               plane_ff[sfcl_pkg::PLANE_NEAR] <= sfcl_pkg::plane_type'(csr_wdata);
            end
            sfcl_pkg::CSR_NEAR_DIST: begin
               near_ff <= csr_wdata[sfcl_pkg::NEAR_W-1:0];
            end
            sfcl_pkg::CSR_INV_RANGE: begin
               inv_ff <= csr_wdata[sfcl_pkg::INV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // valid chain, a stage loads when empty or when the next one moves
   always_comb begin
      rdy[sfcl_pkg::NUM_STAGES-1] = !vld_ff[sfcl_pkg::NUM_STAGES-1] || rsp_ready;
      for (int k = sfcl_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < sfcl_pkg::NUM_STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign pipe_ctl.load = rdy;
   assign req_ready     = rdy[0];

   for (genvar p = 0; p < sfcl_pkg::PLANE_COUNT; p++) begin : g_lane
      sfcl_plane_lane u_lane (
         .clock         (clock),
         .ctl           (pipe_ctl),
         .plane         (plane_ff[p]),
         .centre_x      (req_payload.centre_x),
         .centre_y      (req_payload.centre_y),
         .centre_z      (req_payload.centre_z),
         .sphere_radius (req_payload.sphere_radius),
         .dist_sum      (lane_sum[p])
      );
   end

   // cull test and near-plane span
   assign s_near   = lane_sum[sfcl_pkg::PLANE_NEAR];
   assign near_ext = $signed({{(sfcl_pkg::DIST_W - sfcl_pkg::NEAR_W
                                - sfcl_pkg::FRAC_SHIFT){1'b0}},
                              near_ff, {sfcl_pkg::FRAC_SHIFT{1'b0}}});
   assign diff     = s_near - near_ext;
   assign depth_in = s_near[sfcl_pkg::DEPTH_W+sfcl_pkg::FRAC_SHIFT-1:sfcl_pkg::FRAC_SHIFT];

   always_comb begin
      culled_in = 1'b0;
      for (int p = 0; p < sfcl_pkg::PLANE_COUNT; p++) begin
         if (lane_sum[p][sfcl_pkg::DIST_W-1] || lane_sum[p] == '0) begin
            culled_in = 1'b1;
         end
      end
      if (!culled_in && !diff[sfcl_pkg::DIST_W-1] && diff != '0) begin
         span_in = diff[sfcl_pkg::T_W-1:0];
      end else begin
         span_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[sfcl_pkg::STG_CULL]) begin
         culled_s3_ff <= culled_in;
         depth_s3_ff  <= depth_in;
         span_ff      <= span_in;
      end
      if (rdy[sfcl_pkg::STG_SCALE]) begin
         culled_s4_ff <= culled_s3_ff;
         depth_s4_ff  <= depth_s3_ff;
      end
      if (rdy[sfcl_pkg::STG_OUT]) begin
         visible_ff <= !culled_s4_ff;
         depth_ff   <= culled_s4_ff ? '0 : depth_s4_ff;
      end
   end

   sfcl_detail_scale u_detail (
      .clock         (clock),
      .ctl           (pipe_ctl),
      .span          (span_ff),
      .inverse_range (inv_ff),
      .detail_level  (detail)
   );

   assign rsp_valid                = vld_ff[sfcl_pkg::STG_OUT];
   assign rsp_payload.visible      = visible_ff;
   assign rsp_payload.near_depth   = depth_ff;
   assign rsp_payload.detail_level = detail;

   `SFCL_ASSERT_IMP(a_culled_zero, clock, reset, rsp_valid && !rsp_payload.visible, rsp_payload.near_depth == '0 && rsp_payload.detail_level == '0)
   `SFCL_ASSERT_NXT(a_fill_count, clock, reset, req_valid && req_ready && !(rsp_valid && rsp_ready), $countones(vld_ff) == $past($countones(vld_ff)) + 1)
   `SFCL_ASSERT_NXT(a_drain_count, clock, reset, !(req_valid && req_ready) && rsp_valid && rsp_ready, $countones(vld_ff) + 1 == $past($countones(vld_ff)))
   `SFCL_ASSERT_IMP(a_room_ready, clock, reset, vld_ff != '1, req_ready)

endmodule

/* bench/tb_sphere_frustum_cull_lod.sv */
// testbench for sphere_frustum_cull_lod: drives spheres and plane registers, predicts
// cull, depth and detail level per sphere and checks every result beat in order
// depends on sfcl_pkg and the sphere_frustum_cull_lod top level
`timescale 1ns / 1ps

module tb_sphere_frustum_cull_lod;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam logic [63:0] DEPTH_SAT = (64'd1 << sfcl_pkg::DEPTH_W) - 1;
   localparam logic [63:0] LOD_SAT = (64'd1 << sfcl_pkg::DETAIL_W) - 1;
   localparam logic [63:0] RANGE_ONE = 64'd1 << 36;
   localparam logic [sfcl_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [sfcl_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_B = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   sfcl_pkg::req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   sfcl_pkg::rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [sfcl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sfcl_pkg::CSR_DATA_W-1:0] csr_wdata;

   // register image
   sfcl_pkg::plane_type plane_cfg [sfcl_pkg::PLANE_COUNT];
   logic [sfcl_pkg::NEAR_W-1:0] near_cfg;
   logic [sfcl_pkg::INV_W-1:0] inv_cfg;

   sfcl_pkg::rsp_type pending_lod [$];
   int req_gap_pct;
   int rsp_stall_pct;
   int rsp_stall_left;
   int idle_cycles;
   int mismatches;
   int spheres_sent;
   int results_seen;
   int culled_seen;
   int reg_writes;

   sphere_frustum_cull_lod i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int srand(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // mostly short, now and then long
   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0) return srand(8, 40);
      return srand(1, 3);
   endfunction

   function automatic logic [63:0] make_plane(input int nx, input int ny, input int nz,
                                              input int off);
      sfcl_pkg::plane_type p;
      p.nx = nx[15:0];
      p.ny = ny[15:0];
      p.nz = nz[15:0];
      p.offset = off[15:0];
      return p;
   endfunction

   function automatic sfcl_pkg::req_type make_sphere(input int x, input int y, input int z,
                                                     input int r);
      sfcl_pkg::req_type q;
      q.centre_x = x[15:0];
      q.centre_y = y[15:0];
      q.centre_z = z[15:0];
      q.sphere_radius = r[15:0];
      return q;
   endfunction

   function automatic sfcl_pkg::req_type near_sphere();
      int r;
      r = ($urandom_range(0, 19) == 0) ? srand(0, 65535) : srand(0, 1500);
      return make_sphere(srand(-6000, 6000), srand(-6000, 6000), srand(-2000, 24000), r);
   endfunction

   function automatic sfcl_pkg::req_type noise_sphere();
      return make_sphere($urandom, $urandom, $urandom, $urandom);
   endfunction

   // cull against the four planes in order, then depth and detail from the near plane
   function automatic sfcl_pkg::rsp_type sphere_lod(input sfcl_pkg::req_type sph);
      sfcl_pkg::rsp_type res;
      sfcl_pkg::plane_type p;
      longint cx, cy, cz, rad, off, plane_d;
      logic [63:0] span, depth, nearq, t, hi_part, lo_part, lod;
      bit culled;
      int i;
      cx = $signed(sph.centre_x);
      cy = $signed(sph.centre_y);
      cz = $signed(sph.centre_z);
      rad = sph.sphere_radius;
      rad = rad <<< sfcl_pkg::FRAC_SHIFT;
      culled = 1'b0;
      plane_d = 0;
      for (i = 0; i < sfcl_pkg::PLANE_COUNT; i++) begin
         if (!culled) begin
            p = plane_cfg[i];
            off = $signed(p.offset);
            plane_d = $signed(p.nx) * cx + $signed(p.ny) * cy + $signed(p.nz) * cz
                    + (off <<< sfcl_pkg::FRAC_SHIFT);
            if (plane_d <= -rad) culled = 1'b1;
         end
      end
      res = '0;
      if (!culled) begin
         span = plane_d + rad;
         depth = span >> sfcl_pkg::FRAC_SHIFT;
         if (depth > DEPTH_SAT) depth = DEPTH_SAT;
         nearq = {48'd0, near_cfg} << sfcl_pkg::FRAC_SHIFT;
         lod = 64'd0;
         if (span > nearq) begin
            t = span - nearq;
            hi_part = t * inv_cfg[sfcl_pkg::INV_W-1:sfcl_pkg::INV_HALF];
            lo_part = t * inv_cfg[sfcl_pkg::INV_HALF-1:0];
            lod = (hi_part + (lo_part >> sfcl_pkg::INV_HALF)) >> sfcl_pkg::DETAIL_SHIFT;
            if (lod > LOD_SAT) lod = LOD_SAT;
         end
         res.visible = 1'b1;
         res.near_depth = depth[sfcl_pkg::DEPTH_W-1:0];
         res.detail_level = lod[sfcl_pkg::DETAIL_W-1:0];
      end
      return res;
   endfunction

   // request acceptance, result checking and watchdog
   always @(posedge clock) begin
      sfcl_pkg::rsp_type exp_r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            spheres_sent++;
            pending_lod.push_back(sphere_lod(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (!rsp_payload.visible) culled_seen++;
            if (pending_lod.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result beat: vis=%0b depth=%0d lod=%0d",
                           rsp_payload.visible, rsp_payload.near_depth,
                           rsp_payload.detail_level);
            end else begin
               exp_r = pending_lod.pop_front();
               if (exp_r.visible !== rsp_payload.visible
                   || exp_r.near_depth !== rsp_payload.near_depth
                   || exp_r.detail_level !== rsp_payload.detail_level) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result %0d mismatch: exp vis=%0b depth=%0d lod=%0d, %s",
                              results_seen, exp_r.visible, exp_r.near_depth,
                              exp_r.detail_level, "got");
                  if (mismatches <= MAX_REPORTS)
                     $display("   got vis=%0b depth=%0d lod=%0d",
                              rsp_payload.visible, rsp_payload.near_depth,
                              rsp_payload.detail_level);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat accepted for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (int'($urandom_range(0, 99)) < rsp_stall_pct) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = idle_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // entered and left just after a falling edge
   task automatic push_sphere(input sfcl_pkg::req_type sph);
      int gap;
      gap = (int'($urandom_range(0, 99)) < req_gap_pct) ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= sph;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_lod.size() != 0) @(negedge clock);
      repeat (sfcl_pkg::NUM_STAGES + 3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [sfcl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx) inside
         sfcl_pkg::CSR_PLANE_LEFT, sfcl_pkg::CSR_PLANE_RIGHT,
         sfcl_pkg::CSR_PLANE_FAR, sfcl_pkg::CSR_PLANE_NEAR: begin
            plane_cfg[idx] = data;
         end
         sfcl_pkg::CSR_NEAR_DIST: near_cfg = data[sfcl_pkg::NEAR_W-1:0];
         sfcl_pkg::CSR_INV_RANGE: inv_cfg = data[sfcl_pkg::INV_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // planes all zero: culled only for a zero radius
   task automatic test_reset_state();
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      push_sphere(make_sphere(0, 0, 0, 0));
      push_sphere(make_sphere(100, -100, 50, 1));
      push_sphere(make_sphere(32767, 32767, 32767, 65535));
      push_sphere(make_sphere(-32768, -32768, -32768, 0));
      drain();
   endtask

   task automatic test_directed_frustum();
      req_gap_pct = 30;
      rsp_stall_pct = 30;
      write_reg(sfcl_pkg::CSR_PLANE_LEFT, make_plane(16384, 0, 0, 1600));
      write_reg(sfcl_pkg::CSR_PLANE_RIGHT, make_plane(-16384, 0, 0, 1600));
      write_reg(sfcl_pkg::CSR_PLANE_FAR, make_plane(0, 0, -16384, 16000));
      write_reg(sfcl_pkg::CSR_PLANE_NEAR, make_plane(0, 0, 16384, -160));
      write_reg(sfcl_pkg::CSR_NEAR_DIST, 64'd320);
      write_reg(sfcl_pkg::CSR_INV_RANGE, RANGE_ONE / 8000);
      push_sphere(make_sphere(0, 0, 4000, 16));
      // exactly touching the left plane from outside, then one step in
      push_sphere(make_sphere(-1700, 0, 4000, 100));
      push_sphere(make_sphere(-1700, 0, 4000, 101));
      push_sphere(make_sphere(1800, 0, 4000, 50));
      push_sphere(make_sphere(0, 0, 17000, 100));
      push_sphere(make_sphere(0, 0, 0, 100));
      push_sphere(make_sphere(0, 0, 60, 100));
      // just inside near plane, detail clamped to zero
      push_sphere(make_sphere(0, 0, 61, 100));
      push_sphere(make_sphere(0, 0, 480, 0));
      push_sphere(make_sphere(0, 0, 15000, 0));
      push_sphere(make_sphere(0, 0, 0, 65535));
      push_sphere(make_sphere(32767, 32767, 32767, 65535));
      drain();
   endtask

   // unused indexes are ignored, upper data bits of narrow registers dropped
   task automatic test_register_decode();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      write_reg(CSR_UNUSED_A, '1);
      write_reg(CSR_UNUSED_B, {$urandom, $urandom});
      write_reg(sfcl_pkg::CSR_NEAR_DIST, 64'hFFFF_FFFF_FFFF_0000);
      write_reg(sfcl_pkg::CSR_INV_RANGE, 64'hFFFF_FFFF_FFFF_FFFF);
      push_sphere(make_sphere(0, 0, 4000, 16));
      push_sphere(make_sphere(-100, 0, 200, 0));
      drain();
      write_reg(sfcl_pkg::CSR_NEAR_DIST, 64'hFFFF_FFFF_FFFF_FFFF);
      push_sphere(make_sphere(0, 0, 12000, 900));
      drain();
   endtask

   task automatic test_extreme_planes();
      int i;
      req_gap_pct = 10;
      rsp_stall_pct = 10;
      for (i = 0; i < sfcl_pkg::PLANE_COUNT; i++)
         write_reg(i[sfcl_pkg::CSR_INDEX_W-1:0],
                   make_plane(-32768, -32768, -32768, 32767));
      write_reg(sfcl_pkg::CSR_NEAR_DIST, 64'd0);
      push_sphere(make_sphere(-32768, -32768, -32768, 65535));
      push_sphere(make_sphere(32767, 32767, 32767, 65535));
      drain();
      for (i = 0; i < sfcl_pkg::PLANE_COUNT; i++)
         write_reg(i[sfcl_pkg::CSR_INDEX_W-1:0], '1);
      write_reg(sfcl_pkg::CSR_INV_RANGE, 64'd0);
      push_sphere(make_sphere(-32768, 32767, -1, 3));
      push_sphere(make_sphere(5, 5, 5, 0));
      drain();
   endtask

   task automatic load_frustum(input int setting);
      logic [63:0] data;
      write_reg(sfcl_pkg::CSR_PLANE_LEFT,
                make_plane(srand(9000, 16384), srand(-600, 600),
                           srand(0, 9000), srand(200, 12000)));
      write_reg(sfcl_pkg::CSR_PLANE_RIGHT,
                make_plane(-srand(9000, 16384), srand(-600, 600),
                           srand(0, 9000), srand(200, 12000)));
      write_reg(sfcl_pkg::CSR_PLANE_FAR,
                make_plane(srand(-800, 800), srand(-800, 800),
                           -srand(14000, 16384), srand(4000, 30000)));
      write_reg(sfcl_pkg::CSR_PLANE_NEAR,
                make_plane(srand(-800, 800), srand(-800, 800),
                           srand(14000, 16384), -srand(0, 4000)));
      data = {$urandom, $urandom};
      data[sfcl_pkg::NEAR_W-1:0] = (setting == 0) ? 16'h0000 : (setting == 1) ? 16'hFFFF
                                 : 16'(srand(0, 3000));
      write_reg(sfcl_pkg::CSR_NEAR_DIST, data);
      data = {$urandom, $urandom};
      data[sfcl_pkg::INV_W-1:0] = (setting == 0) ? 32'hFFFF_FFFF : (setting == 1) ? 32'h0
                                : 32'(RANGE_ONE / $urandom_range(2000, 60000));
      write_reg(sfcl_pkg::CSR_INV_RANGE, data);
   endtask

   task automatic test_random_frustums();
      int setting, n;
      for (setting = 0; setting < 8; setting++) begin
         req_gap_pct = (setting % 3 == 0) ? 0 : srand(5, 60);
         rsp_stall_pct = (setting % 4 == 0) ? 0 : srand(5, 60);
         load_frustum(setting);
         for (n = 0; n < 150; n++) begin
            if ($urandom_range(0, 99) < 80) push_sphere(near_sphere());
            else push_sphere(noise_sphere());
         end
         drain();
      end
   endtask

   // arbitrary plane bit patterns, normalized or not
   task automatic test_random_planes();
      int setting, n, i;
      for (setting = 0; setting < 2; setting++) begin
         req_gap_pct = srand(0, 40);
         rsp_stall_pct = srand(0, 40);
         for (i = 0; i < sfcl_pkg::PLANE_COUNT; i++)
            write_reg(i[sfcl_pkg::CSR_INDEX_W-1:0], {$urandom, $urandom});
         write_reg(sfcl_pkg::CSR_NEAR_DIST, {$urandom, $urandom});
         write_reg(sfcl_pkg::CSR_INV_RANGE, {$urandom, $urandom});
         for (n = 0; n < 150; n++) push_sphere(noise_sphere());
         drain();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < sfcl_pkg::PLANE_COUNT; i++) plane_cfg[i] = '0;
      near_cfg = '0;
      inv_cfg = '0;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      rsp_stall_left = 0;
      idle_cycles = 0;
      mismatches = 0;
      spheres_sent = 0;
      results_seen = 0;
      culled_seen = 0;
      reg_writes = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_frustum();
      test_register_decode();
      test_extreme_planes();
      test_random_frustums();
      test_random_planes();
      $display("%0d spheres sent, %0d results checked (%0d culled, %0d visible)",
               spheres_sent, results_seen, culled_seen, results_seen - culled_seen);
      $display("%0d register writes over reset, directed, extreme and random plane sets",
               reg_writes);
      if (mismatches == 0 && pending_lod.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
